// ----- rtl/via_pkg.sv -----
// via_pkg: shared types and constants of the interface adapter
// request kinds, register map, pin numbers, flag bits, item and result structs
// no dependencies
`default_nettype none

package via_pkg;

    typedef enum logic [1:0] {
        REQ_READ  = 2'd0,
        REQ_WRITE = 2'd1,
        REQ_PIN   = 2'd2,
        REQ_TICK  = 2'd3
    } t_req_type;

    typedef enum logic [3:0] {
        ADDR_ORB     = 4'h0,
        ADDR_ORA     = 4'h1,
        ADDR_DDRB    = 4'h2,
        ADDR_DDRA    = 4'h3,
        ADDR_T1C_L   = 4'h4,
        ADDR_T1C_H   = 4'h5,
        ADDR_T1L_L   = 4'h6,
        ADDR_T1L_H   = 4'h7,
        ADDR_T2C_L   = 4'h8,
        ADDR_T2C_H   = 4'h9,
        ADDR_SR      = 4'hA,
        ADDR_ACR     = 4'hB,
        ADDR_PCR     = 4'hC,
        ADDR_IFR     = 4'hD,
        ADDR_IER     = 4'hE,
        ADDR_ORA_NH  = 4'hF
    } t_reg_addr;

    localparam logic [4:0] PIN_CA1 = 5'd8;
    localparam logic [4:0] PIN_PB0 = 5'd10;
    localparam logic [4:0] PIN_PB6 = 5'd16;
    localparam logic [4:0] PIN_CB1 = 5'd18;
    localparam logic [4:0] PIN_END = 5'd20;

    localparam int unsigned FLAG_SR  = 2;
    localparam int unsigned FLAG_T2  = 5;
    localparam int unsigned IER_SET  = 7;
    localparam int unsigned CL_CB1   = 2;
    localparam int unsigned CL_CB2   = 3;
    localparam int unsigned PB_T2CNT = 6;

    localparam logic [3:0] SHIFT_FULL = 4'd8;
    localparam logic [3:0] SHIFT_MAX  = 4'd15;

    typedef struct packed {
        t_req_type   req_type;
        logic [3:0]  addr;
        logic [7:0]  wdata;
        logic [4:0]  pin;
    } t_item;

    typedef struct packed {
        logic [7:0]  rdata;
        logic        irq;
    } t_result;

endpackage

`default_nettype wire

// ----- rtl/via_core.sv -----
// via_core: register file of the interface adapter and the single-pass update logic
// executes one request per enabled cycle and returns its result combinationally
// depends on via_pkg
`default_nettype none

module via_core (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_step,
    input  wire via_pkg::t_item   i_item,
    output via_pkg::t_result      o_result
);

    logic [7:0]  r_port_a_out, n_port_a_out;
    logic [7:0]  r_port_b_out, n_port_b_out;
    logic [7:0]  r_port_a_dir, n_port_a_dir;
    logic [7:0]  r_port_b_dir, n_port_b_dir;
    logic [7:0]  r_port_a_in, n_port_a_in;
    logic [7:0]  r_port_b_in, n_port_b_in;
    logic [15:0] r_timer1_counter, n_timer1_counter;
    logic [15:0] r_t1_reload, n_t1_reload;
    logic [15:0] r_timer2_counter, n_timer2_counter;
    logic [7:0]  r_t2_reload_low, n_t2_reload_low;
    logic        r_t2_armed, n_t2_armed;
    logic [7:0]  r_shift_value, n_shift_value;
    logic [3:0]  r_shift_count, n_shift_count;
    logic [7:0]  r_aux_control, n_aux_control;
    logic [7:0]  r_periph_control, n_periph_control;
    logic [7:0]  r_irq_flags, n_irq_flags;
    logic [6:0]  r_irq_enables, n_irq_enables;
    logic [3:0]  r_control_lines, n_control_lines;

    logic [7:0]  rdata;
    logic        irq;
    logic        level;
    logic [2:0]  pb_idx;
    logic [1:0]  cl_idx;
    logic [15:0] t2_dec;

    assign level  = i_item.wdata[0];
    assign pb_idx = 3'(i_item.pin - via_pkg::PIN_PB0);
    assign cl_idx = {i_item.pin >= via_pkg::PIN_CB1, i_item.pin[0]};
    assign t2_dec = r_timer2_counter - 16'd1;

    always_comb begin
        logic done;
        done             = 1'b0;
        rdata            = 8'd0;
        irq              = 1'b0;
        n_port_a_out     = r_port_a_out;
        n_port_b_out     = r_port_b_out;
        n_port_a_dir     = r_port_a_dir;
        n_port_b_dir     = r_port_b_dir;
        n_port_a_in      = r_port_a_in;
        n_port_b_in      = r_port_b_in;
        n_timer1_counter = r_timer1_counter;
        n_t1_reload      = r_t1_reload;
        n_timer2_counter = r_timer2_counter;
        n_t2_reload_low  = r_t2_reload_low;
        n_t2_armed       = r_t2_armed;
        n_shift_value    = r_shift_value;
        n_shift_count    = r_shift_count;
        n_aux_control    = r_aux_control;
        n_periph_control = r_periph_control;
        n_irq_flags      = r_irq_flags;
        n_irq_enables    = r_irq_enables;
        n_control_lines  = r_control_lines;

        case (i_item.req_type)
            via_pkg::REQ_READ: begin
                case (via_pkg::t_reg_addr'(i_item.addr))
                    via_pkg::ADDR_ORB:
                        rdata = (r_port_b_out & r_port_b_dir) | (r_port_b_in & ~r_port_b_dir);
                    via_pkg::ADDR_DDRB:  rdata = r_port_b_dir;
                    via_pkg::ADDR_DDRA:  rdata = r_port_a_dir;
                    via_pkg::ADDR_T1C_L: rdata = r_timer1_counter[7:0];
                    via_pkg::ADDR_T1C_H: rdata = r_timer1_counter[15:8];
                    via_pkg::ADDR_T1L_L: rdata = r_t1_reload[7:0];
                    via_pkg::ADDR_T1L_H: rdata = r_t1_reload[15:8];
                    via_pkg::ADDR_T2C_L: rdata = r_timer2_counter[7:0];
                    via_pkg::ADDR_T2C_H: rdata = r_timer2_counter[15:8];
                    via_pkg::ADDR_SR: begin
                        rdata                         = r_shift_value;
                        n_shift_count                 = 4'd0;
                        n_irq_flags[via_pkg::FLAG_SR] = 1'b0;
                    end
                    via_pkg::ADDR_ACR:   rdata = r_aux_control;
                    via_pkg::ADDR_PCR:   rdata = r_periph_control;
                    via_pkg::ADDR_IFR:   rdata = r_irq_flags;
                    via_pkg::ADDR_IER:   rdata = {1'b0, r_irq_enables};
                    default:
                        rdata = (r_port_a_out & r_port_a_dir) | (r_port_a_in & ~r_port_a_dir);
                endcase
            end
            via_pkg::REQ_WRITE: begin
                case (via_pkg::t_reg_addr'(i_item.addr))
                    via_pkg::ADDR_ORB:  n_port_b_out = i_item.wdata;
                    via_pkg::ADDR_DDRB: n_port_b_dir = i_item.wdata;
                    via_pkg::ADDR_DDRA: n_port_a_dir = i_item.wdata;
                    via_pkg::ADDR_T1C_L, via_pkg::ADDR_T1L_L:
                        n_t1_reload[7:0] = i_item.wdata;
                    via_pkg::ADDR_T1C_H: n_timer1_counter[15:8] = i_item.wdata;
                    via_pkg::ADDR_T1L_H: n_t1_reload[15:8]      = i_item.wdata;
                    via_pkg::ADDR_T2C_L: n_t2_reload_low        = i_item.wdata;
                    via_pkg::ADDR_T2C_H: begin
                        n_timer2_counter              = {i_item.wdata, r_t2_reload_low};
                        n_irq_flags[via_pkg::FLAG_T2] = 1'b0;
                    end
                    via_pkg::ADDR_SR: begin
                        n_shift_count                 = 4'd0;
                        n_shift_value                 = i_item.wdata;
                        n_irq_flags[via_pkg::FLAG_SR] = 1'b0;
                    end
                    via_pkg::ADDR_ACR: n_aux_control    = i_item.wdata;
                    via_pkg::ADDR_PCR: n_periph_control = i_item.wdata;
                    via_pkg::ADDR_IFR: n_irq_flags      = r_irq_flags & ~i_item.wdata;
                    via_pkg::ADDR_IER: begin
                        if (i_item.wdata[via_pkg::IER_SET]) begin
                            n_irq_enables = r_irq_enables | i_item.wdata[6:0];
                        end else begin
                            n_irq_enables = r_irq_enables & ~i_item.wdata[6:0];
                        end
                    end
                    default: n_port_a_out = i_item.wdata;
                endcase
            end
            via_pkg::REQ_PIN: begin
                // pb6 falling edge counts timer 2
                if (i_item.pin == via_pkg::PIN_PB6
                        && r_port_b_in[via_pkg::PB_T2CNT] && !level) begin
                    n_timer2_counter = t2_dec;
                    if (t2_dec == 16'd0) begin
                        n_t2_armed = 1'b1;
                    end
                end
                // cb1 falling edge shifts cb2 in
                if (i_item.pin == via_pkg::PIN_CB1
                        && r_control_lines[via_pkg::CL_CB1] && !level) begin
                    n_shift_value = {r_shift_value[6:0], r_control_lines[via_pkg::CL_CB2]};
                    if (r_shift_count != via_pkg::SHIFT_MAX) begin
                        n_shift_count = r_shift_count + 4'd1;
                    end
                end
                if (i_item.pin < via_pkg::PIN_CA1) begin
                    if (!r_port_a_dir[i_item.pin[2:0]]) begin
                        n_port_a_in[i_item.pin[2:0]] = level;
                    end
                end else if (i_item.pin < via_pkg::PIN_PB0) begin
                    n_control_lines[cl_idx] = level;
                end else if (i_item.pin < via_pkg::PIN_CB1) begin
                    if (!r_port_b_dir[pb_idx]) begin
                        n_port_b_in[pb_idx] = level;
                    end
                end else if (i_item.pin < via_pkg::PIN_END) begin
                    n_control_lines[cl_idx] = level;
                end
            end
            default: begin
                if (r_shift_count == via_pkg::SHIFT_FULL && !r_irq_flags[via_pkg::FLAG_SR]) begin
                    n_irq_flags[via_pkg::FLAG_SR] = 1'b1;
                    if (r_irq_enables[via_pkg::FLAG_SR]) begin
                        irq  = 1'b1;
                        done = 1'b1;
                    end
                end
                if (!done && r_t2_armed && !r_irq_flags[via_pkg::FLAG_T2]) begin
                    n_t2_armed                    = 1'b0;
                    n_irq_flags[via_pkg::FLAG_T2] = 1'b1;
                    if (r_irq_enables[via_pkg::FLAG_T2]) begin
                        irq  = 1'b1;
                        done = 1'b1;
                    end
                end
                if (!done) begin
                    n_shift_count = {1'b0, r_shift_count[2:0]};
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_port_a_out     <= '0;
            r_port_b_out     <= '0;
            r_port_a_dir     <= '0;
            r_port_b_dir     <= '0;
            r_port_a_in      <= '0;
            r_port_b_in      <= '0;
            r_timer1_counter <= '0;
            r_t1_reload      <= '0;
            r_timer2_counter <= '0;
            r_t2_reload_low  <= '0;
            r_t2_armed       <= 1'b0;
            r_shift_value    <= '0;
            r_shift_count    <= '0;
            r_aux_control    <= '0;
            r_periph_control <= '0;
            r_irq_flags      <= '0;
            r_irq_enables    <= '0;
            r_control_lines  <= '0;
        end else if (i_step) begin
            r_port_a_out     <= n_port_a_out;
            r_port_b_out     <= n_port_b_out;
            r_port_a_dir     <= n_port_a_dir;
            r_port_b_dir     <= n_port_b_dir;
            r_port_a_in      <= n_port_a_in;
            r_port_b_in      <= n_port_b_in;
            r_timer1_counter <= n_timer1_counter;
            r_t1_reload      <= n_t1_reload;
            r_timer2_counter <= n_timer2_counter;
            r_t2_reload_low  <= n_t2_reload_low;
            r_t2_armed       <= n_t2_armed;
            r_shift_value    <= n_shift_value;
            r_shift_count    <= n_shift_count;
            r_aux_control    <= n_aux_control;
            r_periph_control <= n_periph_control;
            r_irq_flags      <= n_irq_flags;
            r_irq_enables    <= n_irq_enables;
            r_control_lines  <= n_control_lines;
        end
    end

    assign o_result.rdata = rdata;
    assign o_result.irq   = irq;

`ifndef SYNTHESIS
    a_tick_quiet_trims_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && i_item.req_type == via_pkg::REQ_TICK && !irq) |=> !r_shift_count[3])
        else $error("shift count above 7 after a quiet tick");

    a_irq_only_on_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        irq |-> (i_item.req_type == via_pkg::REQ_TICK))
        else $error("irq raised by a non-tick request");

    a_sr_read_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && i_item.req_type == via_pkg::REQ_READ
            && i_item.addr == via_pkg::ADDR_SR)
        |=> (r_shift_count == 4'd0 && !r_irq_flags[via_pkg::FLAG_SR]))
        else $error("shift register read did not clear count and flag");
`endif

endmodule

`default_nettype wire

// ----- rtl/versatile_interface_adapter_unit.sv -----
// versatile_interface_adapter_unit: top level of the interface adapter
// input register, via_core update logic and output register on stream ports
// depends on via_pkg and via_core
`default_nettype none

// Each request (bus read, bus write, pin event or tick) yields exactly one
// response, and the block accepts one request per clock while s_axis_tready
// is high. A request is held in the input register until it can advance, is
// executed against the register file by single-pass logic, and its response
// is written to the output register, which drives m_axis_tvalid.
// Throughput is one request per cycle while m_axis_tready is high; the input
// register and the output register each hold one request, so two requests
// can wait on a stalled output before s_axis_tready drops.

module versatile_interface_adapter_unit (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [23:0] s_axis_tdata,   // addr[3:0], wdata[11:4], pin[16:12], zero fill
    input  wire logic [1:0]  s_axis_tuser,   // req_type[1:0]
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [15:0]      m_axis_tdata    // rdata[7:0], irq[8], zero fill
);

    logic             r_in_valid;
    via_pkg::t_item   r_item;
    logic             r_out_valid;
    via_pkg::t_result r_out;
    via_pkg::t_result core_result;
    logic             advance;
    logic             step;
    logic             accept;

    assign advance       = !r_out_valid || m_axis_tready;
    assign step          = r_in_valid && advance;
    assign s_axis_tready = !r_in_valid || advance;
    assign accept        = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_in_valid <= 1'b1;
            end else if (step) begin
                r_in_valid <= 1'b0;
            end
            if (step) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item.req_type <= via_pkg::t_req_type'(s_axis_tuser);
            r_item.addr     <= s_axis_tdata[3:0];
            r_item.wdata    <= s_axis_tdata[11:4];
            r_item.pin      <= s_axis_tdata[16:12];
        end
        if (step) begin
            r_out <= core_result;
        end
    end

    via_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (step),
        .i_item   (r_item),
        .o_result (core_result)
    );

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {7'd0, r_out.irq, r_out.rdata};

`ifndef SYNTHESIS
    a_irq_has_no_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tdata[8]) |-> (m_axis_tdata[7:0] == 8'd0))
        else $error("response carries irq and read data together");

    a_step_fills_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        step |=> r_out_valid)
        else $error("executed request produced no response");

    a_held_request_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !advance) |=> (r_in_valid && $stable(r_item)))
        else $error("pending request lost while output stalled");
`endif

endmodule

`default_nettype wire

// ----- bench/versatile_interface_adapter_unit_tb.sv -----
// versatile_interface_adapter_unit_tb: stream-level test of the interface adapter
// a register-level model predicts every response, a monitor compares them in order
// depends on via_pkg and versatile_interface_adapter_unit
module versatile_interface_adapter_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int          HALF_PERIOD = 5;
    localparam logic [4:0]  PIN_CB2     = 5'd19;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata  = '0;
    logic [1:0]  s_axis_tuser  = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;

    int unsigned send_idle_pct  = 0;
    int unsigned recv_idle_pct  = 0;
    int unsigned sent_count     = 0;
    int unsigned mismatch_count = 0;

    via_pkg::t_result pending_responses[$];

    // model of the adapter registers
    logic [7:0]  pa_out = '0, pb_out = '0, pa_dir = '0, pb_dir = '0;
    logic [7:0]  pa_in = '0, pb_in = '0;
    logic [15:0] tmr1_value = '0, tmr1_reload = '0, tmr2_value = '0;
    logic [7:0]  t2_latch_lo = '0;
    logic        t2_armed = 1'b0;
    logic [7:0]  sr_value = '0;
    logic [3:0]  sr_count = '0;
    logic [7:0]  acr = '0, pcr = '0, ifr = '0;
    logic [6:0]  ier = '0;
    logic [3:0]  ctl_lines = '0;

    versatile_interface_adapter_unit i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),   // addr[3:0], wdata[11:4], pin[16:12], zero fill
        .s_axis_tuser  (s_axis_tuser),   // req_type[1:0]
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)    // rdata[7:0], irq[8], zero fill
    );

    always #(HALF_PERIOD) i_clk = ~i_clk;

    function automatic logic [7:0] port_view(logic [7:0] drv, logic [7:0] pins,
                                             logic [7:0] dir);
        return (drv & dir) | (pins & ~dir);
    endfunction

    function automatic via_pkg::t_result apply_request(via_pkg::t_item req);
        via_pkg::t_result rsp;
        logic             lvl;
        logic             done;
        logic [4:0]       p;
        logic [4:0]       idx;
        rsp  = '0;
        done = 1'b0;
        lvl  = req.wdata[0];
        p    = req.pin;
        case (req.req_type)
            via_pkg::REQ_READ: begin
                case (via_pkg::t_reg_addr'(req.addr))
                    via_pkg::ADDR_ORB:   rsp.rdata = port_view(pb_out, pb_in, pb_dir);
                    via_pkg::ADDR_DDRB:  rsp.rdata = pb_dir;
                    via_pkg::ADDR_DDRA:  rsp.rdata = pa_dir;
                    via_pkg::ADDR_T1C_L: rsp.rdata = tmr1_value[7:0];
                    via_pkg::ADDR_T1C_H: rsp.rdata = tmr1_value[15:8];
                    via_pkg::ADDR_T1L_L: rsp.rdata = tmr1_reload[7:0];
                    via_pkg::ADDR_T1L_H: rsp.rdata = tmr1_reload[15:8];
                    via_pkg::ADDR_T2C_L: rsp.rdata = tmr2_value[7:0];
                    via_pkg::ADDR_T2C_H: rsp.rdata = tmr2_value[15:8];
                    via_pkg::ADDR_SR: begin
                        rsp.rdata             = sr_value;
                        sr_count              = '0;
                        ifr[via_pkg::FLAG_SR] = 1'b0;
                    end
                    via_pkg::ADDR_ACR:   rsp.rdata = acr;
                    via_pkg::ADDR_PCR:   rsp.rdata = pcr;
                    via_pkg::ADDR_IFR:   rsp.rdata = ifr;
                    via_pkg::ADDR_IER:   rsp.rdata = {1'b0, ier};
                    default:             rsp.rdata = port_view(pa_out, pa_in, pa_dir);
                endcase
            end
            via_pkg::REQ_WRITE: begin
                case (via_pkg::t_reg_addr'(req.addr))
                    via_pkg::ADDR_ORB:   pb_out = req.wdata;
                    via_pkg::ADDR_DDRB:  pb_dir = req.wdata;
                    via_pkg::ADDR_DDRA:  pa_dir = req.wdata;
                    via_pkg::ADDR_T1C_L, via_pkg::ADDR_T1L_L:
                        tmr1_reload[7:0] = req.wdata;
                    via_pkg::ADDR_T1C_H: tmr1_value[15:8] = req.wdata;
                    via_pkg::ADDR_T1L_H: tmr1_reload[15:8] = req.wdata;
                    via_pkg::ADDR_T2C_L: t2_latch_lo = req.wdata;
                    via_pkg::ADDR_T2C_H: begin
                        tmr2_value            = {req.wdata, t2_latch_lo};
                        ifr[via_pkg::FLAG_T2] = 1'b0;
                    end
                    via_pkg::ADDR_SR: begin
                        sr_count              = '0;
                        sr_value              = req.wdata;
                        ifr[via_pkg::FLAG_SR] = 1'b0;
                    end
                    via_pkg::ADDR_ACR:   acr = req.wdata;
                    via_pkg::ADDR_PCR:   pcr = req.wdata;
                    via_pkg::ADDR_IFR:   ifr = ifr & ~req.wdata;
                    via_pkg::ADDR_IER: begin
                        if (req.wdata[via_pkg::IER_SET]) begin
                            ier = ier | req.wdata[6:0];
                        end else begin
                            ier = ier & ~req.wdata[6:0];
                        end
                    end
                    default:             pa_out = req.wdata;
                endcase
            end
            via_pkg::REQ_PIN: begin
                // edges use the previously latched levels
                if (p == via_pkg::PIN_PB6 && pb_in[via_pkg::PB_T2CNT] && !lvl) begin
                    tmr2_value = tmr2_value - 16'd1;
                    if (tmr2_value == 16'd0) begin
                        t2_armed = 1'b1;
                    end
                end
                if (p == via_pkg::PIN_CB1 && ctl_lines[via_pkg::CL_CB1] && !lvl) begin
                    sr_value = {sr_value[6:0], ctl_lines[via_pkg::CL_CB2]};
                    if (sr_count != via_pkg::SHIFT_MAX) begin
                        sr_count = sr_count + 4'd1;
                    end
                end
                if (p < via_pkg::PIN_CA1) begin
                    if (!pa_dir[p[2:0]]) begin
                        pa_in[p[2:0]] = lvl;
                    end
                end else if (p < via_pkg::PIN_PB0) begin
                    ctl_lines[p - via_pkg::PIN_CA1] = lvl;
                end else if (p < via_pkg::PIN_CB1) begin
                    idx = p - via_pkg::PIN_PB0;
                    if (!pb_dir[idx[2:0]]) begin
                        pb_in[idx[2:0]] = lvl;
                    end
                end else if (p < via_pkg::PIN_END) begin
                    ctl_lines[p - via_pkg::PIN_CB1 + via_pkg::CL_CB1] = lvl;
                end
            end
            default: begin
                if (sr_count == via_pkg::SHIFT_FULL && !ifr[via_pkg::FLAG_SR]) begin
                    ifr[via_pkg::FLAG_SR] = 1'b1;
                    if (ier[via_pkg::FLAG_SR]) begin
                        rsp.irq = 1'b1;
                        done    = 1'b1;
                    end
                end
                if (!done && t2_armed && !ifr[via_pkg::FLAG_T2]) begin
                    t2_armed              = 1'b0;
                    ifr[via_pkg::FLAG_T2] = 1'b1;
                    if (ier[via_pkg::FLAG_T2]) begin
                        rsp.irq = 1'b1;
                        done    = 1'b1;
                    end
                end
                if (!done) begin
                    sr_count[3] = 1'b0;
                end
            end
        endcase
        return rsp;
    endfunction

    task automatic report_mismatch(string what, int unsigned got, int unsigned want);
        mismatch_count++;
        $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
    endtask

    task automatic send_request(via_pkg::t_req_type kind, logic [3:0] addr,
                                logic [7:0] wdata, logic [4:0] pin);
        via_pkg::t_item req;
        req.req_type = kind;
        req.addr     = addr;
        req.wdata    = wdata;
        req.pin      = pin;
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid = 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tuser  = kind;
        s_axis_tdata  = {7'd0, pin, wdata, addr};
        do @(posedge i_clk); while (!s_axis_tready);
        pending_responses.push_back(apply_request(req));
        sent_count++;
        @(negedge i_clk);
    endtask

    task automatic send_pin(logic [4:0] pin, logic lvl);
        logic [7:0] d;
        d    = 8'($urandom);
        d[0] = lvl;
        send_request(via_pkg::REQ_PIN, 4'($urandom_range(15)), d, pin);
    endtask

    always @(negedge i_clk) begin
        m_axis_tready = ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge i_clk) begin : response_monitor
        via_pkg::t_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_responses.size() == 0) begin
                report_mismatch("response with none expected", m_axis_tdata, 0);
            end else begin
                want = pending_responses.pop_front();
                if (m_axis_tdata[7:0] !== want.rdata) begin
                    report_mismatch("rdata", m_axis_tdata[7:0], want.rdata);
                end
                if (m_axis_tdata[8] !== want.irq) begin
                    report_mismatch("irq", m_axis_tdata[8], want.irq);
                end
            end
        end
    end

    task automatic test_register_access();
        send_request(via_pkg::REQ_WRITE, via_pkg::ADDR_DDRA, 8'hFF, 5'd0);
        send_request(via_pkg::REQ_WRITE, via_pkg::ADDR_ORA, 8'hA5, 5'd31);
        send_request(via_pkg::REQ_READ, via_pkg::ADDR_ORA_NH, 8'h00, 5'd0);
        send_request(via_pkg::REQ_WRITE, via_pkg::ADDR_ACR, 8'hFF, 5'd0);
        send_request(via_pkg::REQ_READ, via_pkg::ADDR_ACR, 8'hFF, 5'd31);
        send_request(via_pkg::REQ_WRITE, via_pkg::ADDR_T1C_H, 8'h80, 5'd0);
        send_request(via_pkg::REQ_READ, via_pkg::ADDR_T1C_H, 8'h00, 5'd0);
    endtask

    task automatic test_port_mixing();
        send_pin(5'd0, 1'b1);
        send_request(via_pkg::REQ_READ, via_pkg::ADDR_ORA, 8'h00, 5'd0);
        send_pin(via_pkg::PIN_PB0 + 5'd7, 1'b1);
        send_request(via_pkg::REQ_READ, via_pkg::ADDR_ORB, 8'h00, 5'd0);
    endtask

    task automatic test_timer2_count();
        send_request(via_pkg::REQ_WRITE, via_pkg::ADDR_T2C_L, 8'h01, 5'd0);
        send_request(via_pkg::REQ_WRITE, via_pkg::ADDR_T2C_H, 8'h00, 5'd0);
        send_pin(via_pkg::PIN_PB6, 1'b1);
        send_pin(via_pkg::PIN_PB6, 1'b0);
        send_request(via_pkg::REQ_WRITE, via_pkg::ADDR_IER, 8'hA0, 5'd0);
        send_request(via_pkg::REQ_TICK, via_pkg::ADDR_ORB, 8'h00, 5'd0);
        send_request(via_pkg::REQ_READ, via_pkg::ADDR_IFR, 8'h00, 5'd0);
    endtask

    task automatic test_shift_register();
        send_pin(PIN_CB2, 1'b1);
        send_pin(via_pkg::PIN_CB1, 1'b1);
        send_pin(via_pkg::PIN_CB1, 1'b0);
        send_request(via_pkg::REQ_READ, via_pkg::ADDR_SR, 8'h00, 5'd0);
    endtask

    task automatic test_unused_pins();
        send_request(via_pkg::REQ_PIN, via_pkg::ADDR_IER, 8'hFF, 5'd31);
        send_request(via_pkg::REQ_WRITE, via_pkg::ADDR_IFR, 8'hFF, 5'd0);
        send_request(via_pkg::REQ_WRITE, via_pkg::ADDR_IER, 8'h7F, 5'd0);
    endtask

    task automatic test_random_traffic(int unsigned sender_idle, int unsigned receiver_idle,
                                       int unsigned n_items);
        int unsigned stop_at;
        int unsigned steps;
        int unsigned pick;
        logic [7:0]  v;
        logic [3:0]  a;
        send_idle_pct = sender_idle;
        recv_idle_pct = receiver_idle;
        stop_at       = sent_count + n_items;
        while (sent_count < stop_at) begin
            case ($urandom_range(9))
                0, 1: begin
                    send_request(via_pkg::t_req_type'($urandom_range(3)),
                                 4'($urandom_range(15)), 8'($urandom),
                                 5'($urandom_range(31)));
                end
                2: begin
                    send_request(via_pkg::REQ_WRITE,
                                 $urandom_range(1) ? via_pkg::ADDR_DDRA : via_pkg::ADDR_DDRB,
                                 8'($urandom), 5'($urandom_range(31)));
                    send_request(via_pkg::REQ_WRITE,
                                 $urandom_range(1) ? via_pkg::ADDR_ORA : via_pkg::ADDR_ORB,
                                 8'($urandom), 5'($urandom_range(31)));
                    steps = $urandom_range(1, 6);
                    repeat (steps) send_pin(5'($urandom_range(17)), 1'($urandom_range(1)));
                    pick = $urandom_range(2);
                    send_request(via_pkg::REQ_READ,
                                 pick == 0 ? via_pkg::ADDR_ORB :
                                 (pick == 1 ? via_pkg::ADDR_ORA : via_pkg::ADDR_ORA_NH),
                                 8'($urandom), 5'($urandom_range(31)));
                end
                3, 4: begin
                    if ($urandom_range(3) == 0) begin
                        v                   = 8'($urandom);
                        v[via_pkg::PB_T2CNT] = ($urandom_range(7) == 0);
                        send_request(via_pkg::REQ_WRITE, via_pkg::ADDR_DDRB, v,
                                     5'($urandom_range(31)));
                    end
                    v = ($urandom_range(7) == 0) ? 8'($urandom) : 8'($urandom_range(5));
                    send_request(via_pkg::REQ_WRITE, via_pkg::ADDR_T2C_L, v,
                                 5'($urandom_range(31)));
                    v = ($urandom_range(7) == 0) ? 8'($urandom) : 8'h00;
                    send_request(via_pkg::REQ_WRITE, via_pkg::ADDR_T2C_H, v,
                                 5'($urandom_range(31)));
                    if ($urandom_range(1)) begin
                        v                  = 8'($urandom);
                        v[via_pkg::IER_SET] = ($urandom_range(3) != 0);
                        send_request(via_pkg::REQ_WRITE, via_pkg::ADDR_IER, v,
                                     5'($urandom_range(31)));
                    end
                    steps = $urandom_range(7);
                    repeat (steps) begin
                        send_pin(via_pkg::PIN_PB6, 1'b1);
                        send_pin(via_pkg::PIN_PB6, 1'b0);
                    end
                    send_request(via_pkg::REQ_TICK, 4'($urandom_range(15)), 8'($urandom),
                                 5'($urandom_range(31)));
                    pick = $urandom_range(2);
                    send_request(via_pkg::REQ_READ,
                                 pick == 0 ? via_pkg::ADDR_IFR :
                                 (pick == 1 ? via_pkg::ADDR_T2C_L : via_pkg::ADDR_T2C_H),
                                 8'($urandom), 5'($urandom_range(31)));
                    if ($urandom_range(1)) begin
                        send_request(via_pkg::REQ_WRITE, via_pkg::ADDR_IFR, 8'($urandom),
                                     5'($urandom_range(31)));
                    end
                end
                5, 6: begin
                    pick = $urandom_range(2);
                    if (pick == 0) begin
                        send_request(via_pkg::REQ_WRITE, via_pkg::ADDR_SR, 8'($urandom),
                                     5'($urandom_range(31)));
                    end else if (pick == 1) begin
                        send_request(via_pkg::REQ_READ, via_pkg::ADDR_SR, 8'($urandom),
                                     5'($urandom_range(31)));
                    end
                    steps = ($urandom_range(4) == 0) ? $urandom_range(17) : $urandom_range(6, 9);
                    repeat (steps) begin
                        send_pin(PIN_CB2, 1'($urandom_range(1)));
                        send_pin(via_pkg::PIN_CB1, 1'b1);
                        send_pin(via_pkg::PIN_CB1, 1'b0);
                    end
                    if ($urandom_range(1)) begin
                        v                  = 8'($urandom);
                        v[via_pkg::IER_SET] = ($urandom_range(3) != 0);
                        send_request(via_pkg::REQ_WRITE, via_pkg::ADDR_IER, v,
                                     5'($urandom_range(31)));
                    end
                    steps = $urandom_range(1, 2);
                    repeat (steps) begin
                        send_request(via_pkg::REQ_TICK, 4'($urandom_range(15)), 8'($urandom),
                                     5'($urandom_range(31)));
                    end
                    send_request(via_pkg::REQ_READ,
                                 $urandom_range(1) ? via_pkg::ADDR_SR : via_pkg::ADDR_IFR,
                                 8'($urandom), 5'($urandom_range(31)));
                end
                7: begin
                    send_request(via_pkg::REQ_WRITE, via_pkg::ADDR_IER, 8'($urandom),
                                 5'($urandom_range(31)));
                    send_request(via_pkg::REQ_WRITE, via_pkg::ADDR_IFR, 8'($urandom),
                                 5'($urandom_range(31)));
                    send_request(via_pkg::REQ_TICK, 4'($urandom_range(15)), 8'($urandom),
                                 5'($urandom_range(31)));
                    send_request(via_pkg::REQ_READ, via_pkg::ADDR_IER, 8'($urandom),
                                 5'($urandom_range(31)));
                end
                8: begin
                    repeat (3) begin
                        send_request(via_pkg::REQ_READ, 4'($urandom_range(15)), 8'($urandom),
                                     5'($urandom_range(31)));
                    end
                end
                default: begin
                    a = 4'($urandom_range(15));
                    send_request(via_pkg::REQ_WRITE, a, 8'($urandom), 5'($urandom_range(31)));
                    send_request(via_pkg::REQ_READ, a, 8'($urandom), 5'($urandom_range(31)));
                end
            endcase
        end
    endtask

    initial begin
        int unsigned drain_cycles;
        drain_cycles = 0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);
        test_register_access();
        test_port_mixing();
        test_timer2_count();
        test_shift_register();
        test_unused_pins();
        test_random_traffic(30, 85, 270);
        test_random_traffic(85, 30, 270);
        test_random_traffic(0, 0, 270);
        s_axis_tvalid = 1'b0;
        while (pending_responses.size() != 0 && drain_cycles < 5000) begin
            @(negedge i_clk);
            drain_cycles++;
        end
        repeat (10) @(negedge i_clk);
        if (pending_responses.size() != 0) begin
            report_mismatch("responses never delivered", pending_responses.size(), 0);
        end
        if (mismatch_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    initial begin
        #2ms;
        $display("FAIL");
        $finish;
    end

endmodule
